FILE: hw/rtl/two_class_block_allocator_macros.svh
// Assertion macros for the two-class block allocator checker.
// Used by tcba_checker.sv; needs nothing else.
`ifndef TWO_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define TWO_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// Property sampled on the rising clock edge and switched off while reset is held.
`define TCBA_ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property sampled on the rising clock edge, also checked through reset.
`define TCBA_ASSERT_RAW(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: hw/rtl/tcba_pkg.sv
// Shared types, codes and constants of the two-class block allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tcba_pkg;

    localparam int unsigned SMALL_BLOCK_BYTES_DEF = 15;
    localparam int unsigned SMALL_BLOCKS_DEF      = 64;
    localparam int unsigned LARGE_BLOCK_BYTES_DEF = 180;
    localparam int unsigned LARGE_BLOCKS_DEF      = 16;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDR_W-1:0] SMALL_BASE_RST = 32'd4096;
    localparam logic [ADDR_W-1:0] LARGE_BASE_RST = 32'd8192;

    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE = 1'b1;

    typedef enum logic [2:0] {
        ST_SMALL_GRANT = 3'd0,
        ST_LARGE_GRANT = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_TOO_LARGE   = 3'd3,
        ST_SMALL_FREED = 3'd4,
        ST_LARGE_FREED = 3'd5,
        ST_IGNORED     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_POP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill;
        logic capture;
        logic exec;
        logic finish_pop;
    } ctl_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic fill_done;
        logic is_pop;
        logic out_free;
    } sts_t;

    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcba_ram.sv
// Single write port, single registered read port RAM holding one free stack.
// Depends on tcba_pkg for the address width helper.
`default_nettype none

module tcba_ram
    import tcba_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [addr_bits(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [addr_bits(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] stack_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            stack_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= stack_mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcba_datapath.sv
// Datapath of the allocator: base registers, request latch, both free stacks,
// stack counters, the reset fill sweep and the result register.
// Depends on tcba_pkg and tcba_ram.
`default_nettype none

module tcba_datapath
    import tcba_pkg::*;
#(
    parameter int SMALL_BLOCK_BYTES = SMALL_BLOCK_BYTES_DEF,
    parameter int SMALL_BLOCKS      = SMALL_BLOCKS_DEF,
    parameter int LARGE_BLOCK_BYTES = LARGE_BLOCK_BYTES_DEF,
    parameter int LARGE_BLOCKS      = LARGE_BLOCKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ctl_t                 ctl,
    output sts_t                      sts,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_wdata,
    input  wire logic [63:0]          s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [ADDR_W-1:0]         m_tdata,
    output logic [2:0]                m_tuser
);

    localparam int S_AW = addr_bits(SMALL_BLOCKS);
    localparam int L_AW = addr_bits(LARGE_BLOCKS);
    localparam int S_CW = $clog2(SMALL_BLOCKS + 1);
    localparam int L_CW = $clog2(LARGE_BLOCKS + 1);
    localparam int S_OW = addr_bits(SMALL_BLOCKS * SMALL_BLOCK_BYTES);
    localparam int L_OW = addr_bits(LARGE_BLOCKS * LARGE_BLOCK_BYTES);
    localparam int MAX_BLOCKS = (SMALL_BLOCKS > LARGE_BLOCKS) ? SMALL_BLOCKS : LARGE_BLOCKS;
    localparam int F_W  = addr_bits(MAX_BLOCKS);
    localparam logic [ADDR_W:0] S_SPAN = (ADDR_W+1)'(SMALL_BLOCKS * SMALL_BLOCK_BYTES);
    localparam logic [ADDR_W:0] L_SPAN = (ADDR_W+1)'(LARGE_BLOCKS * LARGE_BLOCK_BYTES);

    // Configuration.
    logic [ADDR_W-1:0] small_base_reg, small_base_next;
    logic [ADDR_W-1:0] large_base_reg, large_base_next;

    // Request latch.
    logic              cmd_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Stack pointers and reset fill sweep.
    logic [S_CW-1:0] s_cnt_reg, s_cnt_next;
    logic [L_CW-1:0] l_cnt_reg, l_cnt_next;
    logic [F_W-1:0]  fill_idx_reg, fill_idx_next;
    logic [S_OW-1:0] s_fill_off_reg, s_fill_off_next;
    logic [L_OW-1:0] l_fill_off_reg, l_fill_off_next;
    logic            pop_large_reg, pop_large_next;

    // Result register.
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_data_reg, m_data_next;
    status_t           m_status_reg, m_status_next;

    // Decision signals.
    logic [ADDR_W:0]   diff_s, diff_l;
    logic              in_s, in_l, small_fit, large_fit;
    logic              s_pop, l_pop, s_push, l_push, res_load;
    status_t           res_status;
    logic              s_fill_we, l_fill_we;
    logic [S_CW-1:0]   s_cnt_dec;
    logic [L_CW-1:0]   l_cnt_dec;

    // RAM ports.
    logic              s_we, l_we;
    logic [S_AW-1:0]   s_waddr;
    logic [L_AW-1:0]   l_waddr;
    logic [S_OW-1:0]   s_wdata, s_rdata;
    logic [L_OW-1:0]   l_wdata, l_rdata;

    assign diff_s    = {1'b0, addr_reg} - {1'b0, small_base_reg};
    assign diff_l    = {1'b0, addr_reg} - {1'b0, large_base_reg};
    // The borrow bit is clear whenever the address lies at or above the base.
    assign in_s      = (diff_s < S_SPAN);
    assign in_l      = (diff_l < L_SPAN);
    assign small_fit = (size_reg <= SIZE_W'(SMALL_BLOCK_BYTES));
    assign large_fit = (size_reg <= SIZE_W'(LARGE_BLOCK_BYTES));
    assign s_cnt_dec = s_cnt_reg - S_CW'(1);
    assign l_cnt_dec = l_cnt_reg - L_CW'(1);

    always_comb begin
        s_pop      = 1'b0;
        l_pop      = 1'b0;
        s_push     = 1'b0;
        l_push     = 1'b0;
        res_load   = 1'b0;
        res_status = ST_IGNORED;
        if (ctl.exec) begin
            res_load = 1'b1;
            if (!cmd_reg) begin
                priority if (small_fit) begin
                    if (s_cnt_reg != '0) begin
                        s_pop    = 1'b1;
                        res_load = 1'b0;
                    end else begin
                        res_status = ST_EMPTY;
                    end
                end else if (large_fit) begin
                    if (l_cnt_reg != '0) begin
                        l_pop    = 1'b1;
                        res_load = 1'b0;
                    end else begin
                        res_status = ST_EMPTY;
                    end
                end else begin
                    res_status = ST_TOO_LARGE;
                end
            end else if (addr_reg != '0) begin
                // The small pool wins where the two ranges overlap; a full
                // stack means a double free and is ignored.
                priority if (in_s) begin
                    if (s_cnt_reg < S_CW'(SMALL_BLOCKS)) begin
                        s_push     = 1'b1;
                        res_status = ST_SMALL_FREED;
                    end
                end else if (in_l) begin
                    if (l_cnt_reg < L_CW'(LARGE_BLOCKS)) begin
                        l_push     = 1'b1;
                        res_status = ST_LARGE_FREED;
                    end
                end else begin
                    res_status = ST_IGNORED;
                end
            end
        end
    end

    assign s_fill_we = ctl.fill && ({1'b0, fill_idx_reg} < (F_W+1)'(SMALL_BLOCKS));
    assign l_fill_we = ctl.fill && ({1'b0, fill_idx_reg} < (F_W+1)'(LARGE_BLOCKS));

    assign s_we    = s_fill_we || s_push;
    assign l_we    = l_fill_we || l_push;
    assign s_waddr = ctl.fill ? fill_idx_reg[S_AW-1:0] : s_cnt_reg[S_AW-1:0];
    assign l_waddr = ctl.fill ? fill_idx_reg[L_AW-1:0] : l_cnt_reg[L_AW-1:0];
    assign s_wdata = ctl.fill ? s_fill_off_reg : diff_s[S_OW-1:0];
    assign l_wdata = ctl.fill ? l_fill_off_reg : diff_l[L_OW-1:0];

    tcba_ram #(
        .DEPTH(SMALL_BLOCKS),
        .WIDTH(S_OW)
    ) u_small_stack (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_pop),
        .raddr (s_cnt_dec[S_AW-1:0]),
        .rdata (s_rdata)
    );

    tcba_ram #(
        .DEPTH(LARGE_BLOCKS),
        .WIDTH(L_OW)
    ) u_large_stack (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_pop),
        .raddr (l_cnt_dec[L_AW-1:0]),
        .rdata (l_rdata)
    );

    always_comb begin
        small_base_next = small_base_reg;
        large_base_next = large_base_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_SMALL_BASE: small_base_next = cfg_wdata;
                CFG_LARGE_BASE: large_base_next = cfg_wdata;
            endcase
        end
    end

    always_comb begin
        s_cnt_next      = s_cnt_reg;
        l_cnt_next      = l_cnt_reg;
        fill_idx_next   = fill_idx_reg;
        s_fill_off_next = s_fill_off_reg;
        l_fill_off_next = l_fill_off_reg;
        pop_large_next  = pop_large_reg;
        if (ctl.fill) begin
            fill_idx_next   = fill_idx_reg + F_W'(1);
            s_fill_off_next = s_fill_off_reg + S_OW'(SMALL_BLOCK_BYTES);
            l_fill_off_next = l_fill_off_reg + L_OW'(LARGE_BLOCK_BYTES);
        end
        if (s_pop) begin
            s_cnt_next     = s_cnt_dec;
            pop_large_next = 1'b0;
        end
        if (l_pop) begin
            l_cnt_next     = l_cnt_dec;
            pop_large_next = 1'b1;
        end
        if (s_push) begin
            s_cnt_next = s_cnt_reg + S_CW'(1);
        end
        if (l_push) begin
            l_cnt_next = l_cnt_reg + L_CW'(1);
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_load) begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_status_next = res_status;
        end else if (ctl.finish_pop) begin
            m_valid_next = 1'b1;
            if (pop_large_reg) begin
                m_data_next   = large_base_reg + ADDR_W'(l_rdata);
                m_status_next = ST_LARGE_GRANT;
            end else begin
                m_data_next   = small_base_reg + ADDR_W'(s_rdata);
                m_status_next = ST_SMALL_GRANT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_base_reg <= SMALL_BASE_RST;
            large_base_reg <= LARGE_BASE_RST;
            s_cnt_reg      <= S_CW'(SMALL_BLOCKS);
            l_cnt_reg      <= L_CW'(LARGE_BLOCKS);
            fill_idx_reg   <= '0;
            s_fill_off_reg <= '0;
            l_fill_off_reg <= '0;
            pop_large_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            small_base_reg <= small_base_next;
            large_base_reg <= large_base_next;
            s_cnt_reg      <= s_cnt_next;
            l_cnt_reg      <= l_cnt_next;
            fill_idx_reg   <= fill_idx_next;
            s_fill_off_reg <= s_fill_off_next;
            l_fill_off_reg <= l_fill_off_next;
            pop_large_reg  <= pop_large_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg  <= s_tuser;
            size_reg <= s_tdata[SIZE_W-1:0];
            addr_reg <= s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
        end
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign sts.fill_done = (fill_idx_reg == F_W'(MAX_BLOCKS - 1));
    assign sts.is_pop    = s_pop || l_pop;
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcba_ctrl.sv
// Controller state machine of the allocator: reset fill, accept, execute, pop.
// Depends on tcba_pkg.
`default_nettype none

module tcba_ctrl
    import tcba_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output ctl_t      ctl,
    input  wire sts_t sts
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_FILL: begin
                if (sts.fill_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid && sts.out_free) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = sts.is_pop ? S_POP : S_IDLE;
            end
            S_POP: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_FILL: begin
                ctl.fill = 1'b1;
            end
            S_IDLE: begin
                s_tready    = sts.out_free;
                ctl.capture = s_tvalid && sts.out_free;
            end
            S_EXEC: begin
                ctl.exec = 1'b1;
            end
            S_POP: begin
                ctl.finish_pop = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/two_class_block_allocator.sv
// Top level of the two-class fixed-block allocator.
// Depends on tcba_pkg, tcba_ctrl, tcba_datapath and tcba_ram.
//
//  Channel  Dir  Handshake                 Payload
//  s_       in   s_tvalid / s_tready       tdata: req_size, address; tuser: cmd
//  m_       out  m_tvalid / m_tready       tdata: block_address; tuser: status
//  cfg_     in   cfg_we                    cfg_index, cfg_wdata (base registers)
//
// A free, a refused allocate or a too-large request loads the result register when the
// execute state ends; a grant first does the registered read of the stack RAM and loads
// it as the pop state ends. Only one item is in flight; the next is accepted in idle.
// After reset a fill pass loads both stacks with every block offset;
// s_tready stays low meanwhile.
// A stalled result holds the result register and no further item is taken.
`default_nettype none

module two_class_block_allocator
    import tcba_pkg::*;
#(
    parameter int SMALL_BLOCK_BYTES = SMALL_BLOCK_BYTES_DEF,
    parameter int SMALL_BLOCKS      = SMALL_BLOCKS_DEF,
    parameter int LARGE_BLOCK_BYTES = LARGE_BLOCK_BYTES_DEF,
    parameter int LARGE_BLOCKS      = LARGE_BLOCKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // [31:0] req_size, [63:32] address
    input  wire logic                 s_tuser,   // [0] cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [ADDR_W-1:0]         m_tdata,   // [31:0] block_address
    output logic [2:0]                m_tuser,   // [2:0] status
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_wdata
);

    ctl_t ctl;
    sts_t sts;

    tcba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    tcba_datapath #(
        .SMALL_BLOCK_BYTES(SMALL_BLOCK_BYTES),
        .SMALL_BLOCKS     (SMALL_BLOCKS),
        .LARGE_BLOCK_BYTES(LARGE_BLOCK_BYTES),
        .LARGE_BLOCKS     (LARGE_BLOCKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/tcba_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on tcba_pkg and two_class_block_allocator_macros.svh.
`default_nettype none
`include "two_class_block_allocator_macros.svh"

module tcba_checker
    import tcba_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [ADDR_W-1:0] m_tdata,
    input wire logic [2:0]        m_tuser
);

    // A stalled result keeps its value.
    `TCBA_ASSERT_SYNC(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Only a grant carries a non-zero address.
    `TCBA_ASSERT_SYNC(a_zero_unless_grant, aclk, aresetn, m_tvalid && (m_tuser != ST_SMALL_GRANT) && (m_tuser != ST_LARGE_GRANT) |-> (m_tdata == '0), "address given without a grant")

    // One item at a time: the cycle after acceptance takes nothing.
    `TCBA_ASSERT_SYNC(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "item taken while another is in flight")

    // Reset empties the result register and closes the input.
    `TCBA_ASSERT_RAW(a_reset_clears, aclk, !aresetn |=> !m_tvalid && !s_tready, "reset left a result or ready")

endmodule

bind two_class_block_allocator tcba_checker u_tcba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/sv/tcba_tb_pkg.sv
// Command codes shared by the allocator testbench and its checker.
// Depends on nothing; compile it before tcba_reply_checker.sv and testbench.sv.
`timescale 1ns / 100ps

package tcba_tb_pkg;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

endpackage

FILE: tb/sv/tcba_reply_checker.sv
// Checker for the two-class block allocator: keeps its own copy of both free stacks and
// base registers, predicts the reply to every accepted request and compares replies.
// Depends on tcba_pkg and tcba_tb_pkg.
`timescale 1ns / 100ps

module tcba_reply_checker
    import tcba_pkg::*;
    import tcba_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,   // [31:0] req_size, [63:32] address
    input  logic                 s_tuser,   // [0] cmd
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [ADDR_W-1:0]    m_tdata,   // [31:0] block_address
    input  logic [2:0]           m_tuser,   // [2:0] status
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    output int                   mismatch_count,
    output int                   replies_outstanding
);

    localparam longint unsigned SMALL_SPAN = longint'(SMALL_BLOCKS_DEF) * SMALL_BLOCK_BYTES_DEF;
    localparam longint unsigned LARGE_SPAN = longint'(LARGE_BLOCKS_DEF) * LARGE_BLOCK_BYTES_DEF;

    typedef struct {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
    } reply_t;

    reply_t            replies_due[$];
    logic [ADDR_W-1:0] small_base;
    logic [ADDR_W-1:0] large_base;
    logic [ADDR_W-1:0] small_stack [SMALL_BLOCKS_DEF];
    logic [ADDR_W-1:0] large_stack [LARGE_BLOCKS_DEF];
    int unsigned       small_fill;
    int unsigned       large_fill;

    // Both stacks start full, the highest block on top.
    task automatic refill_pools();
        small_base = SMALL_BASE_RST;
        large_base = LARGE_BASE_RST;
        for (int i = 0; i < SMALL_BLOCKS_DEF; i++) begin
            small_stack[i] = i * SMALL_BLOCK_BYTES_DEF;
        end
        for (int i = 0; i < LARGE_BLOCKS_DEF; i++) begin
            large_stack[i] = i * LARGE_BLOCK_BYTES_DEF;
        end
        small_fill = SMALL_BLOCKS_DEF;
        large_fill = LARGE_BLOCKS_DEF;
    endtask

    // The pool range is taken without wrapping past the top of the address space.
    function automatic bit covers(logic [ADDR_W-1:0] address, logic [ADDR_W-1:0] base,
                                  longint unsigned span);
        return ({32'b0, address} >= {32'b0, base}) && ({32'b0, address} < {32'b0, base} + span);
    endfunction

    function automatic reply_t compute_reply(cmd_t cmd, logic [31:0] req_size,
                                             logic [ADDR_W-1:0] address);
        reply_t r;
        r.block_address = '0;
        r.status        = ST_IGNORED;
        if (cmd == CMD_ALLOC) begin
            if (req_size <= SMALL_BLOCK_BYTES_DEF) begin
                if (small_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    small_fill--;
                    r.block_address = small_base + small_stack[small_fill];
                    r.status        = ST_SMALL_GRANT;
                end
            end else if (req_size <= LARGE_BLOCK_BYTES_DEF) begin
                if (large_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    large_fill--;
                    r.block_address = large_base + large_stack[large_fill];
                    r.status        = ST_LARGE_GRANT;
                end
            end else begin
                r.status = ST_TOO_LARGE;
            end
        end else if (address != '0) begin
            // The small pool wins where the two ranges overlap; a full stack refuses the item.
            if (covers(address, small_base, SMALL_SPAN)) begin
                if (small_fill < SMALL_BLOCKS_DEF) begin
                    small_stack[small_fill] = address - small_base;
                    small_fill++;
                    r.status = ST_SMALL_FREED;
                end
            end else if (covers(address, large_base, LARGE_SPAN)) begin
                if (large_fill < LARGE_BLOCKS_DEF) begin
                    large_stack[large_fill] = address - large_base;
                    large_fill++;
                    r.status = ST_LARGE_FREED;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            refill_pools();
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: reply with none awaited: address %h status %0d",
                                 $realtime, m_tdata, m_tuser);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata !== want.block_address || m_tuser !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected address %h status %0d, got address %h status %0d",
                                     $realtime, want.block_address, want.status, m_tdata, m_tuser);
                        end
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SMALL_BASE: small_base = cfg_wdata;
                    CFG_LARGE_BASE: large_base = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                replies_due.push_back(compute_reply(cmd_t'(s_tuser), s_tdata[31:0],
                                                    s_tdata[63:32]));
            end
        end
        replies_outstanding = replies_due.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the allocator testbench: clock, reset, request stimulus and the verdict.
// Depends on tcba_pkg, tcba_tb_pkg, tcba_reply_checker and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
    import tcba_pkg::*;
    import tcba_tb_pkg::*;

    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 167;
    localparam int HEAVY_ITEMS   = 115;
    localparam int STALL_LIMIT   = 3000;
    localparam int unsigned SMALL_SPAN = SMALL_BLOCKS_DEF * SMALL_BLOCK_BYTES_DEF;
    localparam int unsigned LARGE_SPAN = LARGE_BLOCKS_DEF * LARGE_BLOCK_BYTES_DEF;

    typedef struct {
        bit                in_large;
        logic [ADDR_W-1:0] offset;
    } held_block_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // [31:0] req_size, [63:32] address
    logic                 s_tuser   = 1'b0; // [0] cmd
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [ADDR_W-1:0]    m_tdata;          // [31:0] block_address
    logic [2:0]           m_tuser;          // [2:0] status
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;

    int mismatch_count;
    int replies_outstanding;
    int quiet_cycles  = 0;
    int send_idle_pct = 8;
    int recv_idle_pct = 86;

    logic [ADDR_W-1:0] small_base_now = SMALL_BASE_RST;
    logic [ADDR_W-1:0] large_base_now = LARGE_BASE_RST;
    held_block_t       held_blocks[$];

    // Base settings per segment: the reset values, wrap at the top, zero, overlapping pools and both extremes.
    logic [ADDR_W-1:0] small_bases [SEGMENTS] = '{32'h0000_1000, 32'hFFFF_FE00, 32'h0001_0000,
                                                  32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
    logic [ADDR_W-1:0] large_bases [SEGMENTS] = '{32'h0000_2000, 32'h0000_0000, 32'h0001_0000,
                                                  32'hFFFF_FFFF, 32'h7FFF_F000, 32'h0000_1000};

    two_class_block_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tcba_reply_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Granted blocks are kept as pool and offset so that they can still be freed after a
    // change of base.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser == ST_SMALL_GRANT) begin
                held_blocks.push_back('{1'b0, m_tdata - small_base_now});
            end else if (m_tuser == ST_LARGE_GRANT) begin
                held_blocks.push_back('{1'b1, m_tdata - large_base_now});
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_request(cmd_t cmd, logic [31:0] req_size, logic [ADDR_W-1:0] address);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {address, req_size};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (replies_outstanding != 0);
    endtask

    task automatic program_bases(logic [ADDR_W-1:0] small_addr, logic [ADDR_W-1:0] large_addr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SMALL_BASE;
        cfg_wdata <= small_addr;
        @(negedge aclk);
        cfg_index <= CFG_LARGE_BASE;
        cfg_wdata <= large_addr;
        @(negedge aclk);
        cfg_we <= 1'b0;
        small_base_now = small_addr;
        large_base_now = large_addr;
    endtask

    task automatic send_random_request(int alloc_pct);
        cmd_t              cmd;
        logic [31:0]       req_size;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] offset;
        int                pick;
        int                slot;
        held_block_t       blk;
        bit                to_large;
        req_size = $urandom;
        address  = $urandom;
        if ($urandom_range(99) < alloc_pct) begin
            cmd  = CMD_ALLOC;
            pick = $urandom_range(15);
            if (pick < 9) begin
                req_size = $urandom_range(SMALL_BLOCK_BYTES_DEF);
            end else if (pick < 15) begin
                req_size = $urandom_range(LARGE_BLOCK_BYTES_DEF, SMALL_BLOCK_BYTES_DEF + 1);
            end else if (req_size <= LARGE_BLOCK_BYTES_DEF) begin
                req_size = req_size + LARGE_BLOCK_BYTES_DEF + 1;
            end
        end else begin
            cmd  = CMD_FREE;
            pick = $urandom_range(9);
            if (pick < 6 && held_blocks.size() > 0) begin
                slot = $urandom_range(held_blocks.size() - 1);
                blk  = held_blocks[slot];
                held_blocks.delete(slot);
                address = (blk.in_large ? large_base_now : small_base_now) + blk.offset;
            end else if (pick < 8) begin
                // Somewhere inside one pool, on a block boundary or not.
                to_large = 1'($urandom_range(1));
                if ($urandom_range(1)) begin
                    offset = to_large ? $urandom_range(LARGE_BLOCKS_DEF - 1) * LARGE_BLOCK_BYTES_DEF
                                      : $urandom_range(SMALL_BLOCKS_DEF - 1) * SMALL_BLOCK_BYTES_DEF;
                end else begin
                    offset = to_large ? $urandom_range(LARGE_SPAN - 1)
                                      : $urandom_range(SMALL_SPAN - 1);
                end
                address = (to_large ? large_base_now : small_base_now) + offset;
            end else if (pick == 8) begin
                address = '0;
            end
        end
        send_request(cmd, req_size, address);
    endtask

    initial begin
        int seg;
        int n;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Both stacks are full after reset, so frees of pool addresses find no room.
        send_request(CMD_FREE, 32'h0000_0000, SMALL_BASE_RST);
        send_request(CMD_FREE, 32'hFFFF_FFFF, LARGE_BASE_RST);
        send_request(CMD_FREE, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 32'h0000_0000, SMALL_BASE_RST - 1);
        send_request(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, SMALL_BLOCK_BYTES_DEF, 32'h0000_0000);
        send_request(CMD_ALLOC, SMALL_BLOCK_BYTES_DEF + 1, 32'h0000_0000);
        send_request(CMD_ALLOC, LARGE_BLOCK_BYTES_DEF, 32'h0000_0000);
        send_request(CMD_ALLOC, LARGE_BLOCK_BYTES_DEF + 1, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
        // Pool edges, with unaligned addresses pushed back as they are.
        send_request(CMD_FREE, 32'h0000_0000, SMALL_BASE_RST + SMALL_SPAN - 1);
        send_request(CMD_FREE, 32'h0000_0000, SMALL_BASE_RST + SMALL_SPAN);
        send_request(CMD_FREE, 32'h0000_0000, LARGE_BASE_RST + LARGE_SPAN - 1);
        send_request(CMD_FREE, 32'h0000_0000, LARGE_BASE_RST + LARGE_SPAN);
        send_request(CMD_ALLOC, 32'd1, 32'h0000_0000);
        send_request(CMD_ALLOC, 32'd100, 32'h0000_0000);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_replies();
            program_bases(small_bases[seg], large_bases[seg]);
            case (seg / 2)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Mostly allocations first to run the pools dry, then mostly frees to refill them.
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                send_random_request((n < HEAVY_ITEMS) ? 90 : 25);
            end
        end

        drain_replies();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tcba_pkg.sv
hw/rtl/tcba_ram.sv
hw/rtl/tcba_datapath.sv
hw/rtl/tcba_ctrl.sv
hw/rtl/two_class_block_allocator.sv
hw/rtl/tcba_checker.sv
tb/sv/tcba_tb_pkg.sv
tb/sv/tcba_reply_checker.sv
tb/sv/testbench.sv
